// File: rtl/core/smpm_pkg.sv
// ----------------------------------------------------------------------------
// smpm_pkg: shared types and constants of the shift-or pattern matcher
// Field widths, pattern geometry, mode codes and the cell control bundle.
// ----------------------------------------------------------------------------
package smpm_pkg;

  localparam int MAX_PATTERN_LEN = 64;
  localparam int NUM_PATTERNS    = 4;
  localparam int COUNT_BITS      = 16;

  // Fixed field widths of the stream items
  localparam int MODE_W  = 2;
  localparam int PIDX_W  = 2;
  localparam int POS_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int HITS_W  = 3;
  localparam int LINE_W  = 16;

  localparam int HIT_CNT_W = $clog2(NUM_PATTERNS + 1);

  localparam logic [MODE_W-1:0] MODE_CHAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EOL  = 2'd3;

  typedef logic [NUM_PATTERNS-1:0]            pat_vec_t;
  typedef logic [NUM_PATTERNS-1:0][LEN_W-1:0] len_vec_t;

  typedef struct packed {
    logic              step;     // text byte transfer
    logic [BYTE_W-1:0] text;
    logic              wr;       // pattern char load
    logic [PIDX_W-1:0] wr_pat;
    logic [POS_W-1:0]  wr_pos;
    logic [BYTE_W-1:0] wr_char;
    pat_vec_t          restart;  // set vector bits back to ones
  } cell_ctl_t;

endpackage

// File: rtl/core/smpm_cell.sv
// ----------------------------------------------------------------------------
// smpm_cell: one character position of every pattern
// Holds the pattern characters and state bits of its position and passes the
// state bits on to the next position on every text byte.
// ----------------------------------------------------------------------------
module smpm_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  smpm_pkg::cell_ctl_t         ctl,
  input  logic [smpm_pkg::POS_W-1:0]  idx,
  input  smpm_pkg::len_vec_t          lens,
  input  smpm_pkg::pat_vec_t          d_in,
  output smpm_pkg::pat_vec_t          d_out,
  output smpm_pkg::pat_vec_t          hit
);
  import smpm_pkg::*;

  logic [BYTE_W-1:0] chars [NUM_PATTERNS];
  pat_vec_t          d;
  pat_vec_t          d_next;

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (ctl.wr && ctl.wr_pos == idx && int'(ctl.wr_pat) == p) begin
        chars[p] <= ctl.wr_char;
      end
    end
  end

  always_comb begin
    logic [LEN_W-1:0] pos;
    logic             active;
    logic             tap;
    logic             shifted;
    pos    = {1'b0, idx};
    d_next = d;
    hit    = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      active  = pos < lens[p];
      tap     = (lens[p] != '0) && (pos == lens[p] - LEN_W'(1));
      shifted = d_in[p] | ~(active && chars[p] == ctl.text);
      if (ctl.restart[p]) begin
        d_next[p] = 1'b1;
      end else if (ctl.step && lens[p] != '0) begin
        d_next[p] = shifted;
      end
      hit[p] = ctl.step && tap && !shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '1;
    end else begin
      d <= d_next;
    end
  end

  assign d_out = d;

endmodule

// File: rtl/core/smpm_tally.sv
// ----------------------------------------------------------------------------
// smpm_tally: hit count and saturating line counter
// Adds the patterns that end at a text byte to the line count.
// ----------------------------------------------------------------------------
module smpm_tally (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         eol,
  input  smpm_pkg::pat_vec_t           hits,
  output logic [smpm_pkg::HITS_W-1:0]  res_hits,
  output logic [smpm_pkg::LINE_W-1:0]  res_count
);
  import smpm_pkg::*;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_sat;
  logic [HIT_CNT_W-1:0]  pop;
  logic [COUNT_BITS:0]   sum;

  always_comb begin
    pop = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      pop = pop + HIT_CNT_W'(hits[p]);
    end
    sum       = {1'b0, count} + (COUNT_BITS + 1)'(pop);
    count_sat = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (eol) begin
      count <= '0;
    end else if (step) begin
      count <= count_sat;
    end
  end

  always_comb begin
    if (eol) begin
      res_hits  = '0;
      res_count = count[LINE_W-1:0];
    end else begin
      res_hits  = (int'(pop) > 7) ? '1 : HITS_W'(pop);
      res_count = count_sat[LINE_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    eol |=> count == '0)
    else $error("line count not cleared after end of line");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    step && !eol |=> count >= $past(count))
    else $error("line count dropped on a text byte");
`endif

endmodule

// File: rtl/core/shift_or_multi_pattern_matcher.sv
// ----------------------------------------------------------------------------
// shift_or_multi_pattern_matcher: multi-pattern shift-or string matcher
// Chain of per-position cells updating all pattern state vectors per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries the item kind (pattern char load,
//   pattern length load, text byte, end of line); tdata carries the pattern
//   index, char position, byte and length. Loads produce no result; a text
//   byte or an end of line produces one result on m_axis.
//   Output stream m_axis: tdata holds the hits at this byte and the running
//   line count; tlast marks the end-of-line summary, which also clears the
//   state vectors and the count.
//   Output timing: a result is registered and presented in the cycle after its input transfer.
//   Throughput: one item per cycle; the single output register is refilled
//   in the same cycle it is drained, so tready stays high as long as the
//   receiver keeps taking results.
//   Stall: while m_axis_tready is low and a result waits, s_axis_tready is
//   low; nothing is dropped.
//   Reset: synchronous; all patterns disabled (length zero), vectors all
//   ones, count zero. Pattern chars are not cleared and must be loaded
//   before use.
// ----------------------------------------------------------------------------
module shift_or_multi_pattern_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pattern_index, position, byte_value, pattern_len, pad
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // hits_here, line_matches, pad
  output logic        m_axis_tlast   // line_done
);
  import smpm_pkg::*;

  logic              accept;
  logic [MODE_W-1:0] mode;
  logic [PIDX_W-1:0] pidx;
  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] byte_in;
  logic [LEN_W-1:0]  len_in;
  logic [LEN_W-1:0]  len_sat;
  logic              pos_ok;

  len_vec_t          lens;
  cell_ctl_t         ctl;
  pat_vec_t          chain [MAX_PATTERN_LEN + 1];
  pat_vec_t          cell_hit [MAX_PATTERN_LEN];
  pat_vec_t          pat_hit;

  logic [HITS_W-1:0] res_hits;
  logic [LINE_W-1:0] res_count;
  logic              out_valid;
  logic [HITS_W-1:0] out_hits;
  logic [LINE_W-1:0] out_count;
  logic              out_last;

  assign mode    = s_axis_tuser;
  assign pidx    = s_axis_tdata[1:0];
  assign pos     = s_axis_tdata[7:2];
  assign byte_in = s_axis_tdata[15:8];
  assign len_in  = s_axis_tdata[22:16];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign len_sat = (len_in > LEN_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN) : len_in;
  assign pos_ok  = {1'b0, pos} < LEN_W'(MAX_PATTERN_LEN);

  always_comb begin
    ctl.step    = accept && mode == MODE_TEXT;
    ctl.text    = byte_in;
    ctl.wr      = accept && mode == MODE_CHAR;
    ctl.wr_pat  = pidx;
    ctl.wr_pos  = pos;
    ctl.wr_char = byte_in;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      ctl.restart[p] = accept && ((mode == MODE_EOL) ||
        (int'(pidx) == p && ((mode == MODE_CHAR && pos_ok) || mode == MODE_LEN)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lens <= '0;
    end else begin
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (accept && mode == MODE_LEN && int'(pidx) == p) begin
          lens[p] <= len_sat;
        end
      end
    end
  end

  // Zero shifts into position 0.
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_PATTERN_LEN; g++) begin : g_cell
    smpm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .idx   (POS_W'(g)),
      .lens  (lens),
      .d_in  (chain[g]),
      .d_out (chain[g+1]),
      .hit   (cell_hit[g])
    );
  end

  // At most one cell per pattern sits at its tap.
  always_comb begin
    pat_hit = '0;
    for (int g = 0; g < MAX_PATTERN_LEN; g++) begin
      pat_hit = pat_hit | cell_hit[g];
    end
  end

  smpm_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .step      (ctl.step),
    .eol       (accept && mode == MODE_EOL),
    .hits      (pat_hit),
    .res_hits  (res_hits),
    .res_count (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (mode == MODE_TEXT || mode == MODE_EOL)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_TEXT || mode == MODE_EOL)) begin
      out_hits  <= res_hits;
      out_count <= res_count;
      out_last  <= mode == MODE_EOL;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_count, out_hits};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_eol_no_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_hits == '0)
    else $error("end-of-line result carries hits");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_CHAR || mode == MODE_LEN) && m_axis_tready |=> !out_valid)
    else $error("load transfer produced a result");

  a_text_result: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_TEXT |=> out_valid && !out_last)
    else $error("text byte transfer did not produce a byte result");
`endif

endmodule
